[design/dvd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvd_pkg
// Calendar tables and helpers for the date check / day difference / expiry
// pipeline.
// ----------------------------------------------------------------------------
package dvd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int XYEAR_W = YEAR_W + 1;   // expiry walk may pass the field
  localparam int DIFF_W  = 23;
  localparam int CNT_W   = 24;
  localparam int EXP_W   = 9;
  localparam int DOY_W   = 10;           // day of year plus expiry, up to 877
  localparam int CUM_W   = 9;

  localparam logic [EXP_W-1:0]   EXPIRY_RESET = 9'd14;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DOY_W-1:0]   YEAR_DAYS    = 10'd365;
  localparam logic [DOY_W-1:0]   LEAP_DAYS    = 10'd366;

  // 5243 / 2^17 is a close enough reciprocal of 25 for 13-bit operands
  localparam logic [12:0] RECIP25 = 13'd5243;

  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;

  function automatic logic [8:0] div25_f(input logic [12:0] a);
    logic [25:0] p;
    p = 26'(a) * 26'(RECIP25);
    return p[25:17];
  endfunction

  function automatic logic leap_f(input logic [XYEAR_W-1:0] y);
    logic [12:0] a;
    logic [8:0]  q;
    logic        div4;
    logic        div100;
    logic        div400;
    a      = y[XYEAR_W-1:2];
    q      = div25_f(a);
    div4   = (y[1:0] == 2'b00);
    div100 = div4 && (a == 13'(13'(q) * 13'd25));
    div400 = div100 && (q[1:0] == 2'b00);
    return (div4 && !div100) || div400;
  endfunction

  function automatic logic [DAY_W-1:0] dim_f(input month_t m, input logic leap);
    logic [DAY_W-1:0] d;
    d = MONTH_LEN[m];
    if (m == MONTH_FEB && leap) d = 5'd29;
    return d;
  endfunction

  // days in the real months before m; months past December count all twelve
  function automatic logic [CUM_W-1:0] cum_f(input month_t m, input logic leap);
    logic [CUM_W-1:0] s;
    s = '0;
    for (int i = 1; i <= 12; i++) begin
      if (4'(i) < m) s = s + CUM_W'(MONTH_LEN[i]);
    end
    if (leap && m > MONTH_FEB) s = s + 9'd1;
    return s;
  endfunction

endpackage

[design/date_validate_diff_expiry.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_validate_diff_expiry
// Checks two Gregorian dates, gives their day-count difference and the first
// date moved forward by the configured expiry interval.
// ----------------------------------------------------------------------------
// Use:
//   Pulse start with both dates on the in_ ports; the beat is taken at any
//   edge with start high and busy low. busy stays low: the four-stage
//   pipeline takes a new beat every cycle.
//   Each result appears on the out_ ports for one cycle with out_valid high,
//   in the order the beats were taken. The receiver cannot stall, so
//   nothing is held back.
//   Stages: 1) leap tests and reciprocal divides by 25, 2) month tables,
//   validity, year*365 count, 3) day counts and year rollover of the expiry
//   day of year, 4) difference and month search of the expiry date.
//   Throughput is one item per cycle.
//   cfg_data is the expiry interval in days; cfg_ready is always high and
//   writes should land only while no item is in flight.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the expiry
//   interval with 14 days.
//   EPOCH_YEAR sets the first year counted by the day counter.
// ----------------------------------------------------------------------------
module date_validate_diff_expiry #(
  parameter int EPOCH_YEAR = 2000
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  dvd_pkg::day_t             in_first_day,
  input  dvd_pkg::month_t           in_first_month,
  input  dvd_pkg::year_t            in_first_year,
  input  dvd_pkg::day_t             in_second_day,
  input  dvd_pkg::month_t           in_second_month,
  input  dvd_pkg::year_t            in_second_year,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [8:0]                cfg_data,
  output logic                      out_valid,
  output logic                      out_first_valid,
  output logic                      out_second_valid,
  output logic signed [22:0]        out_days_between,
  output dvd_pkg::day_t             out_expiry_day,
  output dvd_pkg::month_t           out_expiry_month,
  output dvd_pkg::year_t            out_expiry_year
);
  import dvd_pkg::*;

  localparam int          EPM1      = EPOCH_YEAR - 1;
  localparam int          LEAPS0    = EPM1 / 4 - EPM1 / 100 + EPM1 / 400;
  localparam year_t       EPOCH_Y   = YEAR_W'(EPOCH_YEAR);
  localparam logic [CNT_W-1:0] LEAPS0_C = CNT_W'(LEAPS0);

  logic accept;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // config register
  logic [EXP_W-1:0] expiry_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      expiry_r <= cfg_data;
    end
  end

  // ---------------- stage 1 ----------------
  logic        s1_vld_r;
  day_t        s1_d_r  [2];
  month_t      s1_m_r  [2];
  year_t       s1_y_r  [2];
  logic        s1_lp_r [2];
  logic [11:0] s1_la_r [2];   // (y-1)/4
  logic [8:0]  s1_lb_r [2];   // (y-1)/100
  logic        s1_lpn1_r;     // leap(first year + 1)
  logic        s1_lpn2_r;     // leap(first year + 2)

  day_t   in_d [2];
  month_t in_m [2];
  year_t  in_y [2];
  assign in_d[0] = in_first_day;
  assign in_d[1] = in_second_day;
  assign in_m[0] = in_first_month;
  assign in_m[1] = in_second_month;
  assign in_y[0] = in_first_year;
  assign in_y[1] = in_second_year;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      logic [YEAR_W-1:0] ym1;
      ym1 = in_y[i] - 14'd1;
      s1_d_r[i]  <= in_d[i];
      s1_m_r[i]  <= in_m[i];
      s1_y_r[i]  <= in_y[i];
      s1_lp_r[i] <= leap_f(XYEAR_W'(in_y[i]));
      s1_la_r[i] <= ym1[YEAR_W-1:2];
      s1_lb_r[i] <= div25_f({1'b0, ym1[YEAR_W-1:2]});
    end
    s1_lpn1_r <= leap_f(XYEAR_W'(in_first_year) + 15'd1);
    s1_lpn2_r <= leap_f(XYEAR_W'(in_first_year) + 15'd2);
  end

  // ---------------- stage 2 ----------------
  logic             s2_vld_r;
  logic             s2_ok_r   [2];
  logic [DOY_W-1:0] s2_cd_r   [2];  // month offset + day
  logic [CNT_W-1:0] s2_base_r [2];  // year part + leap count, LEAPS0 if none
  logic [DOY_W-1:0] s2_doy_r;       // expiry day of year, unrolled
  logic [XYEAR_W-1:0] s2_y_r;
  logic             s2_lp_r;
  logic             s2_lpn1_r;
  logic             s2_lpn2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      logic [DAY_W-1:0] dim;
      logic [CUM_W-1:0] cum;
      logic [YEAR_W-1:0] span;
      logic [CNT_W-1:0] lc;
      dim  = dim_f(s1_m_r[i], s1_lp_r[i]);
      cum  = cum_f(s1_m_r[i], s1_lp_r[i]);
      span = s1_y_r[i] - EPOCH_Y;
      lc   = CNT_W'(s1_la_r[i]) - CNT_W'(s1_lb_r[i]) + CNT_W'(s1_lb_r[i][8:2]);
      s2_ok_r[i] <= (s1_m_r[i] >= MONTH_JAN) && (s1_m_r[i] <= MONTH_DEC) &&
                    (s1_d_r[i] >= 5'd1) && (s1_d_r[i] <= dim);
      s2_cd_r[i] <= DOY_W'(cum) + DOY_W'(s1_d_r[i]);
      if (s1_y_r[i] > EPOCH_Y) begin
        s2_base_r[i] <= CNT_W'(span) * CNT_W'(365) + lc;
      end else begin
        s2_base_r[i] <= LEAPS0_C;
      end
    end
    s2_doy_r  <= DOY_W'(cum_f(s1_m_r[0], s1_lp_r[0])) + DOY_W'(s1_d_r[0]) +
                 DOY_W'(expiry_r);
    s2_y_r    <= XYEAR_W'(s1_y_r[0]);
    s2_lp_r   <= s1_lp_r[0];
    s2_lpn1_r <= s1_lpn1_r;
    s2_lpn2_r <= s1_lpn2_r;
  end

  // ---------------- stage 3 ----------------
  logic               s3_vld_r;
  logic               s3_ok_r  [2];
  logic [CNT_W-1:0]   s3_cnt_r [2];
  logic [8:0]         s3_doy_r;
  logic [XYEAR_W-1:0] s3_y_r;
  logic               s3_lp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [DOY_W-1:0]   doy;
    logic [XYEAR_W-1:0] yy;
    logic               lp;
    for (int i = 0; i < 2; i++) begin
      s3_ok_r[i]  <= s2_ok_r[i];
      s3_cnt_r[i] <= s2_base_r[i] - LEAPS0_C + CNT_W'(s2_cd_r[i]);
    end
    // at most two year rollovers for a 9-bit interval
    doy = s2_doy_r;
    yy  = s2_y_r;
    lp  = s2_lp_r;
    if (doy > (lp ? LEAP_DAYS : YEAR_DAYS)) begin
      doy = doy - (lp ? LEAP_DAYS : YEAR_DAYS);
      yy  = yy + 15'd1;
      lp  = s2_lpn1_r;
      if (doy > (lp ? LEAP_DAYS : YEAR_DAYS)) begin
        doy = doy - (lp ? LEAP_DAYS : YEAR_DAYS);
        yy  = yy + 15'd1;
        lp  = s2_lpn2_r;
      end
    end
    s3_doy_r <= doy[8:0];
    s3_y_r   <= yy;
    s3_lp_r  <= lp;
  end

  // ---------------- stage 4 / outputs ----------------
  logic                     out_vld_r;
  logic                     out_fv_r;
  logic                     out_sv_r;
  logic signed [DIFF_W-1:0] out_diff_r;
  day_t                     out_ed_r;
  month_t                   out_em_r;
  year_t                    out_ey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    month_t           mon;
    logic [CUM_W-1:0] dayn;
    logic [CNT_W-1:0] dd;
    mon = MONTH_JAN;
    for (int k = 2; k <= 12; k++) begin
      if (s3_doy_r > cum_f(4'(k), s3_lp_r)) mon = 4'(k);
    end
    dayn = s3_doy_r - cum_f(mon, s3_lp_r);
    dd   = s3_cnt_r[0] - s3_cnt_r[1];
    out_fv_r   <= s3_ok_r[0];
    out_sv_r   <= s3_ok_r[1];
    out_diff_r <= dd[DIFF_W-1:0];
    if (s3_ok_r[0]) begin
      out_ed_r <= dayn[DAY_W-1:0];
      out_em_r <= mon;
      out_ey_r <= s3_y_r[YEAR_W-1:0];
    end else begin
      out_ed_r <= '0;
      out_em_r <= '0;
      out_ey_r <= '0;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_first_valid  = out_fv_r;
  assign out_second_valid = out_sv_r;
  assign out_days_between = out_diff_r;
  assign out_expiry_day   = out_ed_r;
  assign out_expiry_month = out_em_r;
  assign out_expiry_year  = out_ey_r;

  // ---------------- assertions ----------------
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("accepted beat did not come out after four cycles");

  a_no_ghost : assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##4 !out_valid)
    else $error("result without an accepted beat");

  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_first_valid |->
      out_expiry_day == '0 && out_expiry_month == '0 && out_expiry_year == '0)
    else $error("expiry fields not zero for invalid first date");

  a_expiry_date : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_valid |->
      out_expiry_day >= 5'd1 && out_expiry_month >= MONTH_JAN &&
      out_expiry_month <= MONTH_DEC)
    else $error("expiry date out of calendar range");

endmodule
